@@ hdl/adt_pkg.sv @@
// shared constants and types for the dual timer register block
// register map offsets, global addresses, control bits and command codes
// no dependencies
package adt_pkg;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_t;

  localparam int unsigned ChStride = 20;

  localparam logic [4:0] OFS_LOAD  = 5'h00;
  localparam logic [4:0] OFS_COUNT = 5'h04;
  localparam logic [4:0] OFS_CTRL  = 5'h08;
  localparam logic [4:0] OFS_EOI   = 5'h0c;
  localparam logic [4:0] OFS_STAT  = 5'h10;

  localparam logic [13:0] G_STATUS = 14'h0a0;
  localparam logic [13:0] G_EOI    = 14'h0a4;
  localparam logic [13:0] G_RAW    = 14'h0a8;

  localparam int unsigned CTL_EN_BIT   = 0;
  localparam int unsigned CTL_USER_BIT = 1;
  localparam int unsigned CTL_MASK_BIT = 2;

  localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

endpackage

@@ hdl/apb_dual_timer_registers_core.sv @@
// multi-channel down-counting timer with its bus register file
// each item is a bus read, a bus write or one timer tick; depends on adt_pkg
// path: input register, then result register, between an input transfer and its result transfer
// throughput: one item per clock while results are taken; one result per item
// the result register decouples the sides, the input side stalls only while
// the result register is full and not taken
// reset (rst, synchronous): all channel registers and status flags clear to zero
module apb_dual_timer_registers_core
  import adt_pkg::*;
#(
  parameter int unsigned CHANNELS = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [13:0] address, [45:14] write_data, [47:46] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // [31:0] read_data, [32] irq_zero, [33] irq_one, [39:34] zero
);

  // input register
  logic        in_valid;
  cmd_t        in_cmd;
  logic [13:0] in_addr;
  logic [31:0] in_data;

  // result register
  logic        out_valid;
  logic [31:0] out_rdata;
  logic        out_irq_zero;
  logic        out_irq_one;

  logic advance;
  logic is_global;

  wire  [31:0]         rd_ch [CHANNELS];
  wire  [CHANNELS-1:0] stat_vec;
  wire  [CHANNELS-1:0] act_vec;
  wire  [CHANNELS-1:0] irq_vec;
  logic [31:0]         rd_total;
  logic                irq_one_next;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign is_global     = (in_addr == G_STATUS) || (in_addr == G_EOI) || (in_addr == G_RAW);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd  <= cmd_t'(s_axis_tuser);
      in_addr <= s_axis_tdata[13:0];
      in_data <= s_axis_tdata[45:14];
    end
  end

  for (genvar g = 0; g < CHANNELS; g++) begin : g_ch
    localparam logic [13:0] Base = 14'(g * ChStride);

    logic [31:0] load_value;
    logic [31:0] control_word;
    logic [31:0] reload_limit;
    logic [31:0] current_count;
    logic        status_flag;

    logic [31:0] load_next;
    logic [31:0] control_next;
    logic [31:0] limit_next;
    logic [31:0] count_next;
    logic        status_next;

    logic        hit;
    logic [4:0]  ofs;
    logic        running;
    logic [31:0] rd;

    assign hit     = !is_global && (in_addr >= Base) && (in_addr < Base + 14'(ChStride));
    assign ofs     = 5'(in_addr - Base);
    assign running = control_word[CTL_EN_BIT] && (load_value != '0);

    always_comb begin
      load_next    = load_value;
      control_next = control_word;
      limit_next   = reload_limit;
      count_next   = current_count;
      status_next  = status_flag;
      rd           = '0;
      if (advance) begin
        unique case (in_cmd)
          CMD_READ: begin
            if (in_addr == G_EOI) begin
              status_next = 1'b0;
            end else if (hit) begin
              case (ofs)
                OFS_LOAD:  rd = load_value;
                OFS_COUNT: rd = current_count;
                OFS_CTRL:  rd = control_word;
                OFS_EOI:   status_next = 1'b0;
                OFS_STAT:  rd = 32'(status_flag);
                default:   rd = '0;
              endcase
            end
          end
          CMD_WRITE: begin
            if (hit && ofs == OFS_LOAD) begin
              load_next  = in_data;
              limit_next = in_data;
              count_next = in_data;
            end else if (hit && ofs == OFS_CTRL) begin
              control_next = in_data;
              limit_next   = load_value;
              count_next   = load_value;
            end
          end
          CMD_TICK: begin
            if (running) begin
              if (current_count <= 32'd1) begin
                // expiry: free-run mode reloads from all ones
                status_next = 1'b1;
                if (!control_word[CTL_USER_BIT]) begin
                  limit_next = ALL_ONES;
                end
                count_next = limit_next;
              end else begin
                count_next = current_count - 32'd1;
              end
            end
          end
          default: ;
        endcase
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        load_value    <= '0;
        control_word  <= '0;
        reload_limit  <= '0;
        current_count <= '0;
        status_flag   <= 1'b0;
      end else begin
        load_value    <= load_next;
        control_word  <= control_next;
        reload_limit  <= limit_next;
        current_count <= count_next;
        status_flag   <= status_next;
      end
    end

    assign rd_ch[g]    = rd;
    assign stat_vec[g] = status_flag;
    assign act_vec[g]  = status_flag && !control_word[CTL_MASK_BIT];
    assign irq_vec[g]  = status_next && !control_next[CTL_MASK_BIT];
  end

  always_comb begin
    rd_total = '0;
    if (in_cmd == CMD_READ && in_addr == G_STATUS) begin
      rd_total = 32'(act_vec);
    end else if (in_cmd == CMD_READ && in_addr == G_RAW) begin
      rd_total = 32'(stat_vec);
    end
    for (int i = 0; i < CHANNELS; i++) begin
      rd_total = rd_total | rd_ch[i];
    end
  end

  if (CHANNELS > 1) begin : g_irq_one
    assign irq_one_next = irq_vec[1];
  end else begin : g_no_irq_one
    assign irq_one_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_rdata    <= rd_total;
      out_irq_zero <= irq_vec[0];
      out_irq_one  <= irq_one_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'b0, out_irq_one, out_irq_zero, out_rdata};

endmodule

@@ dv/apb_dual_timer_registers_core_tb.sv @@
// testbench for the dual channel timer register core: directed table, then random traffic
// bus reads, writes and ticks are predicted in-bench and compared per result field
// depends on adt_pkg and apb_dual_timer_registers_core
`timescale 1ns / 100ps

module apb_dual_timer_registers_core_tb;
  import adt_pkg::*;

  localparam int unsigned NUM_CH = 2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 950;
  localparam int unsigned DIRECTED_ROWS = 26;
  localparam int unsigned BUSY_PCT = 38;

  typedef struct packed {
    logic [31:0] rdata;
    logic        irq0;
    logic        irq1;
  } timer_result_t;

  typedef struct {
    logic [1:0]  cmd;
    logic [13:0] addr;
    logic [31:0] wdata;
    bit          known;
    logic [31:0] rdata;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;   // [13:0] address, [45:14] write_data, [47:46] zero
  logic [1:0]  s_axis_tuser;   // [1:0] cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // [31:0] read_data, [32] irq_zero, [33] irq_one, [39:34] zero

  // predicted timer state
  logic [31:0] pred_load  [NUM_CH];
  logic [31:0] pred_ctrl  [NUM_CH];
  logic [31:0] pred_limit [NUM_CH];
  logic [31:0] pred_count [NUM_CH];
  logic        pred_stat  [NUM_CH];

  timer_result_t timer_results_q[$];
  stim_row_t     directed_rows [DIRECTED_ROWS];
  int unsigned   accepted_cnt;
  int unsigned   errors;
  int unsigned   src_idle_pct;
  int unsigned   snk_idle_pct;
  bit            hold_req;

  apb_dual_timer_registers_core #(.CHANNELS(NUM_CH)) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  function automatic logic [13:0] reg_addr(input int unsigned ch, input logic [4:0] ofs);
    return 14'(ch * ChStride) + 14'(ofs);
  endfunction

  function automatic timer_result_t predict_timer_step(input logic [1:0] cmd,
                                                       input logic [13:0] addr,
                                                       input logic [31:0] wdata);
    timer_result_t res;
    int unsigned ch;
    logic [4:0] ofs;
    res = '0;
    ch = addr / ChStride;
    ofs = 5'(addr % ChStride);
    if (cmd == CMD_READ) begin
      if (addr == G_STATUS || addr == G_RAW) begin
        for (int i = 0; i < NUM_CH; i++) begin
          if (addr == G_STATUS)
            res.rdata[i] = pred_stat[i] && !pred_ctrl[i][CTL_MASK_BIT];
          else
            res.rdata[i] = pred_stat[i];
        end
      end else if (addr == G_EOI) begin
        for (int i = 0; i < NUM_CH; i++) pred_stat[i] = 1'b0;
      end else if (ch < NUM_CH) begin
        case (ofs)
          OFS_LOAD:  res.rdata = pred_load[ch];
          OFS_COUNT: res.rdata = pred_count[ch];
          OFS_CTRL:  res.rdata = pred_ctrl[ch];
          OFS_EOI:   pred_stat[ch] = 1'b0;
          OFS_STAT:  res.rdata = {31'd0, pred_stat[ch]};
          default:   res.rdata = '0;
        endcase
      end
    end else if (cmd == CMD_WRITE) begin
      // global addresses fall beyond the channel range, so they drop out here
      if (ch < NUM_CH && (ofs == OFS_LOAD || ofs == OFS_CTRL)) begin
        if (ofs == OFS_LOAD)
          pred_load[ch] = wdata;
        else
          pred_ctrl[ch] = wdata;
        pred_limit[ch] = pred_load[ch];
        pred_count[ch] = pred_load[ch];
      end
    end else if (cmd == CMD_TICK) begin
      for (int i = 0; i < NUM_CH; i++) begin
        if (pred_ctrl[i][CTL_EN_BIT] && pred_load[i] != 0) begin
          if (pred_count[i] <= 1) begin
            pred_stat[i] = 1'b1;
            // free-run mode counts down from all ones after the first expiry
            if (!pred_ctrl[i][CTL_USER_BIT]) pred_limit[i] = ALL_ONES;
            pred_count[i] = pred_limit[i];
          end else begin
            pred_count[i] = pred_count[i] - 1;
          end
        end
      end
    end
    res.irq0 = pred_stat[0] && !pred_ctrl[0][CTL_MASK_BIT];
    res.irq1 = pred_stat[1] && !pred_ctrl[1][CTL_MASK_BIT];
    return res;
  endfunction

  task automatic put_item(input logic [1:0] cmd, input logic [13:0] addr,
                          input logic [31:0] wdata);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {2'b00, wdata, addr};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // result checking and prediction, both on values sampled at the edge
  always @(posedge clk) begin
    timer_result_t got;
    timer_result_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.rdata = m_axis_tdata[31:0];
        got.irq0  = m_axis_tdata[32];
        got.irq1  = m_axis_tdata[33];
        if (timer_results_q.size() == 0) begin
          $display("%0t: result with none pending, got %h", $time, m_axis_tdata);
          errors++;
        end else begin
          want = timer_results_q.pop_front();
          if (got.rdata !== want.rdata) begin
            $display("%0t: read_data expected %h actual %h", $time, want.rdata, got.rdata);
            errors++;
          end
          if (got.irq0 !== want.irq0) begin
            $display("%0t: irq_zero expected %b actual %b", $time, want.irq0, got.irq0);
            errors++;
          end
          if (got.irq1 !== want.irq1) begin
            $display("%0t: irq_one expected %b actual %b", $time, want.irq1, got.irq1);
            errors++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = predict_timer_step(s_axis_tuser, s_axis_tdata[13:0], s_axis_tdata[45:14]);
        if (accepted_cnt < DIRECTED_ROWS && directed_rows[accepted_cnt].known)
          want.rdata = directed_rows[accepted_cnt].rdata;
        timer_results_q.push_back(want);
        accepted_cnt++;
      end
    end
  end

  // result side: random back-pressure plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (80) @(posedge clk);
      end else begin
        m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [1:0]  cmd;
    logic [13:0] addr;
    logic [31:0] wdata;
    int unsigned pick;
    clk = 1'b0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    accepted_cnt = 0;
    errors = 0;
    hold_req = 1'b0;
    src_idle_pct = BUSY_PCT;
    snk_idle_pct = BUSY_PCT;
    for (int i = 0; i < NUM_CH; i++) begin
      pred_load[i] = '0;
      pred_ctrl[i] = '0;
      pred_limit[i] = '0;
      pred_count[i] = '0;
      pred_stat[i] = 1'b0;
    end

    directed_rows = '{
      '{CMD_READ,   reg_addr(0, OFS_LOAD),  32'h0,    1'b1, 32'h0},
      '{CMD_READ,   G_STATUS,               32'h0,    1'b1, 32'h0},
      '{CMD_READ,   G_RAW,                  32'h0,    1'b1, 32'h0},
      '{CMD_WRITE,  reg_addr(0, OFS_LOAD),  32'h2,    1'b0, 32'h0},
      // enabled, free-run, unmasked
      '{CMD_WRITE,  reg_addr(0, OFS_CTRL),  32'h1,    1'b0, 32'h0},
      '{CMD_TICK,   14'h0,                  32'h0,    1'b0, 32'h0},
      '{CMD_TICK,   14'h0,                  32'h0,    1'b0, 32'h0},
      '{CMD_READ,   G_STATUS,               32'h0,    1'b0, 32'h0},
      '{CMD_READ,   reg_addr(0, OFS_COUNT), 32'h0,    1'b0, 32'h0},
      '{CMD_READ,   reg_addr(0, OFS_STAT),  32'h0,    1'b0, 32'h0},
      '{CMD_READ,   reg_addr(0, OFS_EOI),   32'h0,    1'b1, 32'h0},
      '{CMD_WRITE,  reg_addr(1, OFS_LOAD),  ALL_ONES, 1'b0, 32'h0},
      // enabled, user mode, masked
      '{CMD_WRITE,  reg_addr(1, OFS_CTRL),  32'h7,    1'b0, 32'h0},
      '{CMD_TICK,   14'h0,                  32'h0,    1'b0, 32'h0},
      '{CMD_READ,   reg_addr(1, OFS_COUNT), 32'h0,    1'b0, 32'h0},
      '{CMD_WRITE,  reg_addr(1, OFS_LOAD),  32'h1,    1'b0, 32'h0},
      '{CMD_TICK,   14'h0,                  32'h0,    1'b0, 32'h0},
      '{CMD_READ,   G_RAW,                  32'h0,    1'b0, 32'h0},
      '{CMD_READ,   G_STATUS,               32'h0,    1'b0, 32'h0},
      '{CMD_READ,   G_EOI,                  32'h0,    1'b1, 32'h0},
      // not writable: global register, counter; then reads of a channel out of range and an odd offset
      '{CMD_WRITE,  G_STATUS,               ALL_ONES, 1'b0, 32'h0},
      '{CMD_WRITE,  reg_addr(0, OFS_COUNT), 32'h5,    1'b0, 32'h0},
      '{CMD_READ,   reg_addr(2, OFS_LOAD),  32'h0,    1'b1, 32'h0},
      '{CMD_READ,   14'h002,                32'h0,    1'b1, 32'h0},
      '{CMD_UNUSED, 14'h3fff,               ALL_ONES, 1'b1, 32'h0},
      '{CMD_READ,   14'h3fff,               32'h0,    1'b1, 32'h0}
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[r])
      put_item(directed_rows[r].cmd, directed_rows[r].addr, directed_rows[r].wdata);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // a stretch with no idling on either side
      if (n == 300) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      if (n == 450) begin
        src_idle_pct = BUSY_PCT;
        snk_idle_pct = BUSY_PCT;
      end
      // keep offering while the result side holds off
      if (n == 600) begin
        src_idle_pct = 0;
        hold_req = 1'b1;
      end
      if (n == 720) src_idle_pct = BUSY_PCT;

      pick = $urandom_range(99);
      if (pick < 35)
        cmd = CMD_TICK;
      else if (pick < 70)
        cmd = CMD_READ;
      else if (pick < 95)
        cmd = CMD_WRITE;
      else
        cmd = CMD_UNUSED;

      pick = $urandom_range(99);
      if (pick < 70) begin
        case ($urandom_range(7))
          0: addr = reg_addr($urandom_range(NUM_CH - 1), OFS_LOAD);
          1: addr = reg_addr($urandom_range(NUM_CH - 1), OFS_COUNT);
          2: addr = reg_addr($urandom_range(NUM_CH - 1), OFS_CTRL);
          3: addr = reg_addr($urandom_range(NUM_CH - 1), OFS_EOI);
          4: addr = reg_addr($urandom_range(NUM_CH - 1), OFS_STAT);
          5: addr = G_STATUS;
          6: addr = G_EOI;
          default: addr = G_RAW;
        endcase
      end else if (pick < 85) begin
        // odd offsets and the first channel slot past the end
        addr = 14'($urandom_range(3 * ChStride - 1));
      end else begin
        addr = 14'($urandom_range(14'h3fff));
      end

      // small loads so that counters expire often
      if ($urandom_range(4) == 0)
        wdata = $urandom();
      else
        wdata = 32'($urandom_range(7));

      put_item(cmd, addr, wdata);
    end
    s_axis_tvalid <= 1'b0;
    // let the last transfer reach the prediction queue first
    @(posedge clk);

    while (timer_results_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
